[src/ring_fifo_with_segment_lengths_top_macros.svh]
// Assertion macros for the ring FIFO with segment lengths
`ifndef RING_FIFO_WITH_SEGMENT_LENGTHS_TOP_MACROS_SVH
`define RING_FIFO_WITH_SEGMENT_LENGTHS_TOP_MACROS_SVH

// flag a condition that must never hold
`define RFSL_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

// require a consequence in the same cycle as its antecedent
`define RFSL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[src/rfsl_pkg.sv]
// Shared types and constants for the ring FIFO with segment lengths
package rfsl_pkg;

    localparam int DEPTH   = 8;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int LEN_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = 32;
    localparam int Q_DEPTH = 2;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_PUSH    = 3'd1,
        OP_POP     = 3'd2,
        OP_PEEK    = 3'd3,
        OP_WRITE   = 3'd4,
        OP_ADVANCE = 3'd5,
        OP_READ    = 3'd6,
        OP_STATUS  = 3'd7
    } op_t;

    typedef enum logic {
        BK_TAKE,
        BK_RESP
    } back_state_t;

    typedef struct packed {
        op_t                  op;
        logic [ENTRY_W-1:0]   entry;
        logic [IDX_W-1:0]     slot;
        logic [3:0]           count;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

[src/rfsl_front.sv]
// Front end: accepts input words, decodes them into commands and queues them
module rfsl_front import rfsl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [15:0] s_task_id,
    input  logic [15:0] s_proc_addr,
    input  logic [2:0]  s_slot,
    input  logic [3:0]  s_count,
    output hs_t         q_hs_out,
    input  logic        q_take,
    output cmd_t        q_cmd
);

    cmd_t            q_mem [Q_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] cnt_reg, cnt_next;
    cmd_t            dec_cmd;
    logic            push;
    logic            pop;

    always_comb begin
        dec_cmd.op    = op_t'(s_action);
        dec_cmd.entry = {s_task_id, s_proc_addr};
        dec_cmd.slot  = IDX_W'(32'(s_slot) % DEPTH);
        dec_cmd.count = s_count;
    end

    assign s_ready        = (cnt_reg != QC_W'(Q_DEPTH));
    assign push           = s_valid && s_ready;
    assign q_hs_out.valid = (cnt_reg != '0);
    assign q_hs_out.ready = s_ready;
    assign pop            = q_take && q_hs_out.valid;
    assign q_cmd          = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

[src/rfsl_back.sv]
// Back end: executes commands on the ring store and registers the result word
module rfsl_back import rfsl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  hs_t         q_hs_in,
    output logic        q_take,
    input  cmd_t        q_cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [15:0] m_out_task,
    output logic [15:0] m_out_addr,
    output logic        m_is_empty,
    output logic        m_is_full,
    output logic [3:0]  m_len_to_end,
    output logic [3:0]  m_len_from_start
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic             full_reg, full_next;
    logic             ok_reg, ok_next;
    logic             show_reg, show_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_ok_reg, m_ok_next;
    logic [15:0]      m_task_reg, m_task_next;
    logic [15:0]      m_addr_reg, m_addr_next;
    logic             m_empty_reg, m_empty_next;
    logic             m_full_reg, m_full_next;
    logic [3:0]       m_lte_reg, m_lte_next;
    logic [3:0]       m_lfs_reg, m_lfs_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] tail_inc;
    logic [LEN_W-1:0] occ;
    logic [LEN_W-1:0] free_cnt;
    logic [LEN_W-1:0] adv_cnt;
    logic [LEN_W:0]   tail_sum;
    logic [IDX_W-1:0] tail_adv;
    logic             take;

    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    always_comb begin
        if (empty_reg) begin
            occ = '0;
        end else if (full_reg) begin
            occ = LEN_W'(DEPTH);
        end else if (tail_reg > head_reg) begin
            occ = LEN_W'(tail_reg) - LEN_W'(head_reg);
        end else begin
            occ = LEN_W'(tail_reg) + LEN_W'(DEPTH) - LEN_W'(head_reg);
        end
        free_cnt = LEN_W'(DEPTH) - occ;
        adv_cnt  = ({1'b0, q_cmd.count} > (LEN_W + 1)'(free_cnt)) ? free_cnt
                                                                    : LEN_W'(q_cmd.count);
        tail_sum = (LEN_W + 1)'(tail_reg) + (LEN_W + 1)'(adv_cnt);
        tail_adv = (tail_sum >= (LEN_W + 1)'(DEPTH)) ? IDX_W'(tail_sum - (LEN_W + 1)'(DEPTH))
                                                     : IDX_W'(tail_sum);
    end

    assign take   = (state_reg == BK_TAKE) && q_hs_in.valid && (!m_valid_reg || m_ready);
    assign q_take = take;

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        empty_next   = empty_reg;
        full_next    = full_reg;
        ok_next      = ok_reg;
        show_next    = show_reg;
        we           = 1'b0;
        waddr        = q_cmd.slot;
        raddr        = q_cmd.slot;
        m_valid_next = m_valid_reg && !m_ready;
        m_ok_next    = m_ok_reg;
        m_task_next  = m_task_reg;
        m_addr_next  = m_addr_reg;
        m_empty_next = m_empty_reg;
        m_full_next  = m_full_reg;
        m_lte_next   = m_lte_reg;
        m_lfs_next   = m_lfs_reg;

        case (state_reg)
            BK_TAKE: begin
                if (take) begin
                    state_next = BK_RESP;
                    ok_next    = 1'b1;
                    show_next  = 1'b0;
                    case (q_cmd.op)
                        OP_CLEAR: begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                            full_next  = 1'b0;
                        end
                        OP_PUSH: begin
                            if (full_reg) begin
                                ok_next = 1'b0;
                            end else begin
                                we         = 1'b1;
                                waddr      = tail_reg;
                                tail_next  = tail_inc;
                                full_next  = (tail_inc == head_reg);
                                empty_next = 1'b0;
                            end
                        end
                        OP_POP: begin
                            raddr = head_reg;
                            if (empty_reg) begin
                                ok_next = 1'b0;
                            end else begin
                                show_next  = 1'b1;
                                head_next  = head_inc;
                                empty_next = (head_inc == tail_reg);
                                full_next  = 1'b0;
                            end
                        end
                        OP_PEEK: begin
                            raddr = head_reg;
                            if (empty_reg) begin
                                ok_next = 1'b0;
                            end else begin
                                show_next = 1'b1;
                            end
                        end
                        OP_WRITE: begin
                            we = 1'b1;
                        end
                        OP_ADVANCE: begin
                            if (adv_cnt != '0) begin
                                tail_next  = tail_adv;
                                full_next  = full_reg || (tail_adv == head_reg);
                                empty_next = 1'b0;
                            end
                        end
                        OP_READ: begin
                            show_next = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_RESP: begin
                state_next   = BK_TAKE;
                m_valid_next = 1'b1;
                m_ok_next    = ok_reg;
                m_task_next  = show_reg ? rdata_reg[31:16] : 16'd0;
                m_addr_next  = show_reg ? rdata_reg[15:0] : 16'd0;
                m_empty_next = empty_reg;
                m_full_next  = full_reg;
                if (empty_reg) begin
                    m_lte_next = '0;
                    m_lfs_next = '0;
                end else if (tail_reg > head_reg) begin
                    m_lte_next = 4'(tail_reg) - 4'(head_reg);
                    m_lfs_next = '0;
                end else begin
                    m_lte_next = 4'(DEPTH) - 4'(head_reg);
                    m_lfs_next = 4'(tail_reg);
                end
            end
            default: begin
                state_next = BK_TAKE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_TAKE;
            head_reg    <= '0;
            tail_reg    <= '0;
            empty_reg   <= 1'b1;
            full_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            empty_reg   <= empty_next;
            full_reg    <= full_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg      <= ok_next;
        show_reg    <= show_next;
        m_ok_reg    <= m_ok_next;
        m_task_reg  <= m_task_next;
        m_addr_reg  <= m_addr_next;
        m_empty_reg <= m_empty_next;
        m_full_reg  <= m_full_next;
        m_lte_reg   <= m_lte_next;
        m_lfs_reg   <= m_lfs_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= q_cmd.entry;
        end
        rdata_reg <= mem[raddr];
    end

    assign m_valid          = m_valid_reg;
    assign m_ok             = m_ok_reg;
    assign m_out_task       = m_task_reg;
    assign m_out_addr       = m_addr_reg;
    assign m_is_empty       = m_empty_reg;
    assign m_is_full        = m_full_reg;
    assign m_len_to_end     = m_lte_reg;
    assign m_len_from_start = m_lfs_reg;

endmodule

[src/ring_fifo_with_segment_lengths_top.sv]
// Top level of the ring FIFO with segment lengths
// Each input word is one action on an eight-entry ring of (task id, processor
// address) entries: clear, push, pop, peek, slot write, tail advance, slot read
// or status. Every word yields exactly one result word with the outcome, the
// entry read (or zero), the empty and full flags after the action and the two
// occupied segment lengths. Input words enter a two-word command queue; the
// execution stage takes one word in its take state, where it updates the
// indices and reads the store, then loads the result register in its
// response state before it takes the next word; it does not take a word
// while a result is held by a stalled result side. Store entries are not
// cleared by reset or by the clear action.
`include "ring_fifo_with_segment_lengths_top_macros.svh"

module ring_fifo_with_segment_lengths_top import rfsl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [15:0] s_task_id,
    input  logic [15:0] s_proc_addr,
    input  logic [2:0]  s_slot,
    input  logic [3:0]  s_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [15:0] m_out_task,
    output logic [15:0] m_out_addr,
    output logic        m_is_empty,
    output logic        m_is_full,
    output logic [3:0]  m_len_to_end,
    output logic [3:0]  m_len_from_start
);

    hs_t  q_hs;
    logic q_take;
    cmd_t q_cmd;

    rfsl_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_task_id   (s_task_id),
        .s_proc_addr (s_proc_addr),
        .s_slot      (s_slot),
        .s_count     (s_count),
        .q_hs_out    (q_hs),
        .q_take      (q_take),
        .q_cmd       (q_cmd)
    );

    rfsl_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_hs_in          (q_hs),
        .q_take           (q_take),
        .q_cmd            (q_cmd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_out_task       (m_out_task),
        .m_out_addr       (m_out_addr),
        .m_is_empty       (m_is_empty),
        .m_is_full        (m_is_full),
        .m_len_to_end     (m_len_to_end),
        .m_len_from_start (m_len_from_start)
    );

    `RFSL_ASSERT_NEVER(a_empty_and_full, m_valid && m_is_empty && m_is_full, "empty and full together")
    `RFSL_ASSERT_IMPLIES(a_empty_lengths, m_valid && m_is_empty, (m_len_to_end == 4'd0) && (m_len_from_start == 4'd0), "nonzero length while empty")
    `RFSL_ASSERT_IMPLIES(a_fail_no_data, m_valid && !m_ok, (m_out_task == 16'd0) && (m_out_addr == 16'd0), "data on failed action")
    `RFSL_ASSERT_NEVER(a_take_empty_queue, q_take && !q_hs.valid, "command taken from empty queue")

endmodule

[test/ring_fifo_with_segment_lengths_top_tb.sv]
// Self-checking testbench for the ring FIFO with segment lengths
`timescale 1ns / 1ps

module ring_fifo_with_segment_lengths_top_tb;
    import rfsl_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 450;
    localparam int CHUNK_WORDS  = 50;

    typedef struct {
        logic        ok;
        logic [15:0] out_task;
        logic [15:0] out_addr;
        logic        is_empty;
        logic        is_full;
        logic [3:0]  len_to_end;
        logic [3:0]  len_from_start;
    } ring_result_t;

    class ring_scoreboard;
        logic [IDX_W-1:0]   head_idx;
        logic [IDX_W-1:0]   tail_idx;
        bit                 empty_now;
        bit                 full_now;
        logic [ENTRY_W-1:0] entries [DEPTH];
        ring_result_t       pending [$];
        int                 mismatches;

        function new();
            head_idx   = '0;
            tail_idx   = '0;
            empty_now  = 1'b1;
            full_now   = 1'b0;
            mismatches = 0;
        endfunction

        function void note_action(op_t op, logic [15:0] tid, logic [15:0] paddr,
                                  logic [2:0] slot, logic [3:0] count);
            ring_result_t       r;
            logic [ENTRY_W-1:0] entry;
            int unsigned        occupied;
            int unsigned        room;
            int unsigned        step;
            r.ok  = 1'b1;
            entry = '0;
            case (op)
                OP_CLEAR: begin
                    head_idx  = '0;
                    tail_idx  = '0;
                    empty_now = 1'b1;
                    full_now  = 1'b0;
                end
                OP_PUSH: begin
                    if (full_now) begin
                        r.ok = 1'b0;
                    end else begin
                        entries[tail_idx] = {tid, paddr};
                        tail_idx  = IDX_W'((tail_idx + 1) % DEPTH);
                        full_now  = (tail_idx == head_idx);
                        empty_now = 1'b0;
                    end
                end
                OP_POP: begin
                    if (empty_now) begin
                        r.ok = 1'b0;
                    end else begin
                        entry     = entries[head_idx];
                        head_idx  = IDX_W'((head_idx + 1) % DEPTH);
                        empty_now = (head_idx == tail_idx);
                        full_now  = 1'b0;
                    end
                end
                OP_PEEK: begin
                    if (empty_now)
                        r.ok = 1'b0;
                    else
                        entry = entries[head_idx];
                end
                OP_WRITE: entries[slot % DEPTH] = {tid, paddr};
                OP_ADVANCE: begin
                    if (empty_now)
                        occupied = 0;
                    else if (full_now)
                        occupied = DEPTH;
                    else
                        occupied = (tail_idx + DEPTH - head_idx) % DEPTH;
                    room = DEPTH - occupied;
                    step = (count > room) ? room : count;
                    if (step != 0) begin
                        tail_idx = IDX_W'((tail_idx + step) % DEPTH);
                        if (tail_idx == head_idx)
                            full_now = 1'b1;
                        empty_now = 1'b0;
                    end
                end
                OP_READ: entry = entries[slot % DEPTH];
                default: ;
            endcase
            r.out_task = entry[31:16];
            r.out_addr = entry[15:0];
            r.is_empty = empty_now;
            r.is_full  = full_now;
            if (empty_now) begin
                r.len_to_end     = '0;
                r.len_from_start = '0;
            end else if (tail_idx > head_idx) begin
                r.len_to_end     = 4'(tail_idx - head_idx);
                r.len_from_start = '0;
            end else begin
                r.len_to_end     = 4'(DEPTH - head_idx);
                r.len_from_start = 4'(tail_idx);
            end
            pending.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            end
        endfunction

        function void check_result(ring_result_t act);
            ring_result_t exp;
            if (pending.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing expected", $time);
                return;
            end
            exp = pending.pop_front();
            compare_field("ok", exp.ok, act.ok);
            compare_field("out_task", exp.out_task, act.out_task);
            compare_field("out_addr", exp.out_addr, act.out_addr);
            compare_field("is_empty", exp.is_empty, act.is_empty);
            compare_field("is_full", exp.is_full, act.is_full);
            compare_field("len_to_end", exp.len_to_end, act.len_to_end);
            compare_field("len_from_start", exp.len_from_start, act.len_from_start);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_action;
    logic [15:0] s_task_id;
    logic [15:0] s_proc_addr;
    logic [2:0]  s_slot;
    logic [3:0]  s_count;
    logic        m_valid;
    logic        m_ready;
    logic        m_ok;
    logic [15:0] m_out_task;
    logic [15:0] m_out_addr;
    logic        m_is_empty;
    logic        m_is_full;
    logic [3:0]  m_len_to_end;
    logic [3:0]  m_len_from_start;

    ring_scoreboard sb;
    bit             steady_flow;
    int             cycle_count = 0;

    ring_fifo_with_segment_lengths_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_task_id        (s_task_id),
        .s_proc_addr      (s_proc_addr),
        .s_slot           (s_slot),
        .s_count          (s_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_out_task       (m_out_task),
        .m_out_addr       (m_out_addr),
        .m_is_empty       (m_is_empty),
        .m_is_full        (m_is_full),
        .m_len_to_end     (m_len_to_end),
        .m_len_from_start (m_len_from_start)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[ring_fifo_with_segment_lengths_top] ERROR");
            $finish;
        end
    end

    task automatic send_action(op_t op, logic [15:0] tid, logic [15:0] paddr,
                               logic [2:0] slot, logic [3:0] count);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= op;
        s_task_id   <= tid;
        s_proc_addr <= paddr;
        s_slot      <= slot;
        s_count     <= count;
        do @(posedge aclk); while (!s_ready);
        sb.note_action(op, tid, paddr, slot, count);
    endtask

    task automatic drain_results();
        ring_result_t act;
        int           stall;
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            act.ok             = m_ok;
            act.out_task       = m_out_task;
            act.out_addr       = m_out_addr;
            act.is_empty       = m_is_empty;
            act.is_full        = m_is_full;
            act.len_to_end     = m_len_to_end;
            act.len_from_start = m_len_from_start;
            sb.check_result(act);
        end
    endtask

    task automatic send_random_word(int bias);
        int   pick;
        int   push_w;
        int   pop_w;
        op_t  op;
        push_w = (bias == 0) ? 45 : (bias == 1) ? 15 : 30;
        pop_w  = 60 - push_w;
        pick   = $urandom_range(0, 99);
        if (pick < push_w)
            op = OP_PUSH;
        else if (pick < 60)
            op = OP_POP;
        else if (pick < 68)
            op = OP_PEEK;
        else if (pick < 76)
            op = OP_WRITE;
        else if (pick < 84)
            op = OP_READ;
        else if (pick < 92)
            op = OP_ADVANCE;
        else if (pick < 97)
            op = OP_STATUS;
        else
            op = OP_CLEAR;
        send_action(op, 16'($urandom), 16'($urandom), 3'($urandom_range(0, 7)),
                    4'($urandom_range(0, 8)));
    endtask

    initial begin
        sb          = new();
        steady_flow = 1'b0;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_action    <= OP_STATUS;
        s_task_id   <= '0;
        s_proc_addr <= '0;
        s_slot      <= '0;
        s_count     <= '0;
        m_ready     <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            drain_results();
        join_none

        // fill every slot so later reads never touch an unwritten entry
        send_action(OP_WRITE, 16'hFFFF, 16'h0000, 3'd0, 4'd0);
        send_action(OP_WRITE, 16'h0000, 16'hFFFF, 3'd1, 4'd0);
        send_action(OP_WRITE, 16'hFFFF, 16'hFFFF, 3'd2, 4'd0);
        send_action(OP_WRITE, 16'h0000, 16'h0000, 3'd3, 4'd0);
        send_action(OP_WRITE, 16'h5A5A, 16'hA5A5, 3'd4, 4'd0);
        send_action(OP_WRITE, 16'hA5A5, 16'h5A5A, 3'd5, 4'd0);
        send_action(OP_WRITE, 16'h8001, 16'h7FFE, 3'd6, 4'd0);
        send_action(OP_WRITE, 16'h1234, 16'hFEDC, 3'd7, 4'd0);
        send_action(OP_STATUS, 16'hFFFF, 16'hFFFF, 3'd7, 4'd15);
        send_action(OP_POP, 16'h0, 16'h0, 3'd0, 4'd0);
        send_action(OP_PEEK, 16'h0, 16'h0, 3'd0, 4'd0);
        send_action(OP_READ, 16'h0, 16'h0, 3'd7, 4'd0);
        send_action(OP_PUSH, 16'hFFFF, 16'hFFFF, 3'd0, 4'd0);
        send_action(OP_PEEK, 16'h0, 16'h0, 3'd0, 4'd0);
        send_action(OP_POP, 16'h0, 16'h0, 3'd0, 4'd0);
        send_action(OP_ADVANCE, 16'h0, 16'h0, 3'd0, 4'd0);
        send_action(OP_ADVANCE, 16'h0, 16'h0, 3'd0, 4'd8);
        send_action(OP_PUSH, 16'hBEEF, 16'hCAFE, 3'd0, 4'd0);
        send_action(OP_ADVANCE, 16'h0, 16'h0, 3'd0, 4'd3);
        send_action(OP_POP, 16'h0, 16'h0, 3'd0, 4'd0);
        send_action(OP_ADVANCE, 16'h0, 16'h0, 3'd0, 4'd8);
        send_action(OP_CLEAR, 16'h0, 16'h0, 3'd0, 4'd0);
        send_action(OP_ADVANCE, 16'h0, 16'h0, 3'd0, 4'd5);
        send_action(OP_READ, 16'h0, 16'h0, 3'd3, 4'd0);
        send_action(OP_STATUS, 16'h0, 16'h0, 3'd0, 4'd0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % CHUNK_WORDS == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            send_random_word((n / CHUNK_WORDS) % 3);
        end
        steady_flow = 1'b0;
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("[ring_fifo_with_segment_lengths_top] OK");
        end else begin
            $display("[ring_fifo_with_segment_lengths_top] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/rfsl_pkg.sv
src/rfsl_front.sv
src/rfsl_back.sv
src/ring_fifo_with_segment_lengths_top.sv
test/ring_fifo_with_segment_lengths_top_tb.sv
